// ===== src/ray_walk_edge_finder_core_macros.svh =====
// assertion helpers shared by the core
`ifndef RAY_WALK_EDGE_FINDER_CORE_MACROS_SVH
`define RAY_WALK_EDGE_FINDER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RWEF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RWEF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rwef_pkg.sv =====
package rwef_pkg;

    // default sizes
    localparam int MAX_STEPS_DEF  = 32;
    localparam int IMG_WIDTH_DEF  = 128;
    localparam int IMG_HEIGHT_DEF = 128;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_SLOPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_USE = 2'd3;

    localparam logic [7:0]  THRESHOLD_RST  = 8'd25;
    localparam logic [15:0] COST_SLOPE_RST = 16'd256;
    localparam logic [7:0]  WIDTH_USE_RST  = 8'd128;
    localparam logic [7:0]  HEIGHT_USE_RST = 8'd128;

    // item function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    typedef struct packed {
        logic               func;
        logic [6:0]         pixel_x;
        logic [6:0]         pixel_y;
        logic [7:0]         pixel_value;
        logic [6:0]         seed_x;
        logic [6:0]         seed_y;
        logic signed [15:0] ray_dx;
        logic signed [15:0] ray_dy;
    } t_in_word;

    typedef struct packed {
        logic       edge_found;
        logic [6:0] edge_x;
        logic [6:0] edge_y;
        logic [4:0] edge_step;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_WALK,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic write_px;
        logic load;
        logic issue_seed;
        logic issue_step;
        logic finish;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic iss_done;
        logic cmp_vld;
        logic hit;
        logic last_cmp;
        logic out_free;
    } t_stat;

endpackage

// ===== src/rwef_ram.sv =====
module rwef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/rwef_ctrl.sv =====
module rwef_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_func,
    output logic            o_in_stall,
    input  rwef_pkg::t_stat i_stat,
    output rwef_pkg::t_cmd  o_cmd
);

    import rwef_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_RAY) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_SEED;
                    end else begin
                        o_cmd.write_px = 1'b1;
                    end
                end
            end
            ST_SEED: begin
                o_cmd.issue_seed = 1'b1;
                n_state          = ST_WALK;
            end
            ST_WALK: begin
                if (i_stat.cmp_vld && (i_stat.hit || i_stat.last_cmp)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_PUSH;
                end else begin
                    o_cmd.issue_step = !i_stat.iss_done;
                end
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rwef_dp.sv =====
module rwef_dp #(
    parameter int MAX_STEPS  = rwef_pkg::MAX_STEPS_DEF,
    parameter int IMG_WIDTH  = rwef_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = rwef_pkg::IMG_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rwef_pkg::t_cmd     i_cmd,
    output rwef_pkg::t_stat    o_stat,
    input  rwef_pkg::t_in_word i_in_word,
    input  logic [7:0]         i_threshold,
    input  logic [15:0]        i_cost_slope,
    input  logic [7:0]         i_width_use,
    input  logic [7:0]         i_height_use,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rwef_pkg::t_out_word o_out_word
);

    import rwef_pkg::*;

    localparam int XW    = $clog2(IMG_WIDTH);
    localparam int YW    = $clog2(IMG_HEIGHT);
    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW    = $clog2(MAX_STEPS + 1);
    localparam int ACC_W = 24 + SW;
    localparam int QW    = ACC_W - 14;
    localparam int KW    = 16 + CW;
    localparam int LXW   = ((XW > 8) ? XW : 8) + 1;
    localparam int LYW   = ((YW > 8) ? YW : 8) + 1;
    localparam int SXW   = ((XW > 7) ? XW : 7) + 1;
    localparam int SYW   = ((YW > 7) ? YW : 7) + 1;

    localparam logic [AW-1:0] ROW_PITCH = AW'(IMG_WIDTH);

    // walk state
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic signed [15:0]      r_dx, r_dy;
    logic [XW-1:0]           r_x_max, r_sx_c;
    logic [YW-1:0]           r_y_max, r_sy_c;
    logic [KW-1:0]           r_cost;
    logic [CW-1:0]           r_iss_cnt;
    logic                    r_seed_pend;
    logic [7:0]              r_seed_pix;

    // compare stage, lines up with the ram read data
    logic                    r_cmp_vld;
    logic [XW-1:0]           r_q_x;
    logic [YW-1:0]           r_q_y;
    logic [SW-1:0]           r_q_step;
    logic [KW-1:0]           r_q_cost;

    t_out_word               r_res;
    t_out_word               r_out;
    logic                    r_out_vld;

    // limits of the area in use
    logic [LXW-1:0] wu_e, wu_m1;
    logic [LYW-1:0] hu_e, hu_m1;
    logic [XW-1:0]  x_max;
    logic [YW-1:0]  y_max;

    assign wu_e  = LXW'(i_width_use);
    assign wu_m1 = wu_e - LXW'(1);
    assign hu_e  = LYW'(i_height_use);
    assign hu_m1 = hu_e - LYW'(1);

    always_comb begin
        if (i_width_use == 8'd0) begin
            x_max = '0;
        end else if (wu_e > LXW'(IMG_WIDTH)) begin
            x_max = XW'(IMG_WIDTH - 1);
        end else begin
            x_max = wu_m1[XW-1:0];
        end
        if (i_height_use == 8'd0) begin
            y_max = '0;
        end else if (hu_e > LYW'(IMG_HEIGHT)) begin
            y_max = YW'(IMG_HEIGHT - 1);
        end else begin
            y_max = hu_m1[YW-1:0];
        end
    end

    // seed pixel location, clamped to the store
    logic [SXW-1:0] sx_e, px_e;
    logic [SYW-1:0] sy_e, py_e;
    logic [XW-1:0]  sx_c;
    logic [YW-1:0]  sy_c;

    assign sx_e = SXW'(i_in_word.seed_x);
    assign sy_e = SYW'(i_in_word.seed_y);
    assign px_e = SXW'(i_in_word.pixel_x);
    assign py_e = SYW'(i_in_word.pixel_y);
    assign sx_c = (sx_e > SXW'(IMG_WIDTH - 1))  ? XW'(IMG_WIDTH - 1)  : sx_e[XW-1:0];
    assign sy_c = (sy_e > SYW'(IMG_HEIGHT - 1)) ? YW'(IMG_HEIGHT - 1) : sy_e[YW-1:0];

    // current point: negative position clamps to zero, else integer part vs limit
    logic [QW-1:0] q_x, q_y;
    logic [XW-1:0] pt_x;
    logic [YW-1:0] pt_y;

    assign q_x  = r_acc_x[ACC_W-1:14];
    assign q_y  = r_acc_y[ACC_W-1:14];
    assign pt_x = r_acc_x[ACC_W-1] ? '0 :
                  (q_x > QW'(r_x_max)) ? r_x_max : q_x[XW-1:0];
    assign pt_y = r_acc_y[ACC_W-1] ? '0 :
                  (q_y > QW'(r_y_max)) ? r_y_max : q_y[YW-1:0];

    // image store
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    assign wr_en   = i_cmd.write_px && (px_e < SXW'(IMG_WIDTH)) && (py_e < SYW'(IMG_HEIGHT));
    assign wr_addr = AW'(i_in_word.pixel_y) * ROW_PITCH + AW'(i_in_word.pixel_x);
    assign rd_addr = i_cmd.issue_seed ? (AW'(r_sy_c) * ROW_PITCH + AW'(r_sx_c))
                                      : (AW'(pt_y) * ROW_PITCH + AW'(pt_x));

    rwef_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_img (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_word.pixel_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // edge test: (pix - seed - thr) * 256 > cost
    logic signed [10:0] diff;
    logic               hit;

    assign diff = 11'({3'b000, rd_data}) - 11'({3'b000, r_seed_pix})
                - 11'({3'b000, i_threshold});
    assign hit  = r_cmp_vld && !diff[10] && (KW'({diff[7:0], 8'h00}) > r_q_cost);

    logic [XW+6:0] res_x;
    logic [YW+6:0] res_y;
    logic [SW+4:0] res_step;

    assign res_x    = {7'd0, r_q_x};
    assign res_y    = {7'd0, r_q_y};
    assign res_step = {5'd0, r_q_step};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_x <= ACC_W'({i_in_word.seed_x, 14'd0});
            r_acc_y <= ACC_W'({i_in_word.seed_y, 14'd0});
            r_dx    <= i_in_word.ray_dx;
            r_dy    <= i_in_word.ray_dy;
            r_x_max <= x_max;
            r_y_max <= y_max;
            r_sx_c  <= sx_c;
            r_sy_c  <= sy_c;
            r_cost  <= KW'(i_cost_slope) * KW'(MAX_STEPS);
        end else if (i_cmd.issue_step) begin
            r_acc_x <= r_acc_x + ACC_W'(r_dx);
            r_acc_y <= r_acc_y + ACC_W'(r_dy);
            r_cost  <= r_cost - KW'(i_cost_slope);
        end
        if (i_cmd.issue_step) begin
            r_q_x    <= pt_x;
            r_q_y    <= pt_y;
            r_q_step <= r_iss_cnt[SW-1:0];
            r_q_cost <= r_cost;
        end
        if (r_seed_pend) begin
            r_seed_pix <= rd_data;
        end
        if (i_cmd.finish) begin
            if (hit) begin
                r_res.edge_found <= 1'b1;
                r_res.edge_x     <= res_x[6:0];
                r_res.edge_y     <= res_y[6:0];
                r_res.edge_step  <= res_step[4:0];
            end else begin
                r_res <= '0;
            end
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_cnt   <= '0;
            r_seed_pend <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_iss_cnt <= '0;
            end else if (i_cmd.issue_step) begin
                r_iss_cnt <= r_iss_cnt + CW'(1);
            end
            r_seed_pend <= i_cmd.issue_seed;
            r_cmp_vld   <= i_cmd.issue_step;
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.iss_done = (r_iss_cnt == CW'(MAX_STEPS));
    assign o_stat.cmp_vld  = r_cmp_vld;
    assign o_stat.hit      = hit;
    assign o_stat.last_cmp = (r_q_step == SW'(MAX_STEPS - 1));
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ===== src/ray_walk_edge_finder_core.sv =====
// ray walk edge finder: pupil edge search along rays over a stored grey image
// input channel (i_in_valid / o_in_stall, word i_in_word) carries two kinds of word:
//   func = pixel: writes one 8-bit pixel into the image store if inside it, no result
//   func = ray: walks up to MAX_STEPS points from the seed along (ray_dx, ray_dy)
//   in Q1.14 and returns one result word with the first edge point, if any
// o_out_valid rises after a ray is accepted once the walk ends, at the first edge or
// after the last step: one seed read, one ram read per step through the single read
// port, one compare tail and a move of the result into the output register, which
// waits while that register is full and stalled; the next word is taken once the
// controller is back in idle after that move
// a new word is taken while the previous result still waits in the output register
// output channel (o_out_valid / i_out_stall, word o_out_word) holds its word while
// stalled; a finished ray waits in the controller until the output register frees
// configuration is a plain write port, to be used only while the block is idle
// reset (i_rst_n low, synchronous) restores the register defaults and empties the
// pipe; the image store is not cleared and holds garbage until written
`include "ray_walk_edge_finder_core_macros.svh"

module ray_walk_edge_finder_core #(
    parameter int MAX_STEPS  = rwef_pkg::MAX_STEPS_DEF,
    parameter int IMG_WIDTH  = rwef_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = rwef_pkg::IMG_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rwef_pkg::t_in_word                i_in_word,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rwef_pkg::t_out_word               o_out_word,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [rwef_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rwef_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import rwef_pkg::*;

    // configuration registers
    logic [7:0]  r_threshold;
    logic [15:0] r_cost_slope;
    logic [7:0]  r_width_use;
    logic [7:0]  r_height_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_cost_slope <= COST_SLOPE_RST;
            r_width_use  <= WIDTH_USE_RST;
            r_height_use <= HEIGHT_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[7:0];
                CFG_COST_SLOPE: r_cost_slope <= i_cfg_data;
                CFG_WIDTH_USE:  r_width_use  <= i_cfg_data[7:0];
                CFG_HEIGHT_USE: r_height_use <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // controller to datapath commands and status flags
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing: idle, seed read, step walk, result hand-off
    rwef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_word.func),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // image store, point stepping, clamping, edge test and output register
    rwef_dp #(
        .MAX_STEPS  (MAX_STEPS),
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_word    (i_in_word),
        .i_threshold  (r_threshold),
        .i_cost_slope (r_cost_slope),
        .i_width_use  (r_width_use),
        .i_height_use (r_height_use),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

    // a result is only moved when the output register can take it
    `RWEF_ASSERT_IMP(a_push_room, w_cmd.push, !o_out_valid || !i_out_stall, "push into full output")
    // an accepted ray keeps the input side closed in the next cycle
    `RWEF_ASSERT_NXT(a_ray_busy, i_in_valid && !o_in_stall && i_in_word.func, o_in_stall, "ray not held off")
    // seed read and step read never share the read port
    `RWEF_ASSERT_IMP(a_one_read, w_cmd.issue_seed, !w_cmd.issue_step, "two reads in one cycle")
    // a pushed result shows on the output in the next cycle
    `RWEF_ASSERT_NXT(a_push_shows, w_cmd.push, o_out_valid, "pushed result not shown")

endmodule
